>>> hw/rtl/mred_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mred_pkg
// shared types and constants of the multiscale ratio edge detector
// ----------------------------------------------------------------------------
package mred_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int PIXEL_BITS = 16;
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int SUM_BITS   = PIXEL_BITS + 5;
    localparam int THR_BITS   = 16;
    localparam int PROD_BITS  = SUM_BITS + THR_BITS;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_THR_SMALL  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THR_MEDIUM = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_THR_LARGE  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT     = 3'd4;

    localparam logic [7:0] EDGE_YES = 8'd0;
    localparam logic [7:0] EDGE_NO  = 8'd255;

    typedef logic [PIXEL_BITS-1:0] pixel_t;
    typedef pixel_t [5:0] line_entry_t;          // entry k holds row r-1-k
    typedef pixel_t [6:0][6:0] win_t;            // [row][col], row 6 / col 6 newest
    typedef logic [THR_BITS-1:0] thr_t;
    typedef thr_t [2:0] thr_set_t;               // small, medium, large
    typedef logic [SUM_BITS-1:0] sum_t;
    typedef sum_t [2:0] trio_t;                  // centre line, side block 1, side block 2
    typedef trio_t [3:0] dir_sums_t;             // four directions

    // per-item control travelling with the data
    typedef struct packed {
        logic       emit;
        logic       last;
        logic [2:0] fits;
    } tag_t;

endpackage : mred_pkg
`default_nettype wire

>>> hw/rtl/mred_item_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mred_item_if
// input pixel channel: command and magnitude
// ----------------------------------------------------------------------------
interface mred_item_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [15:0] magnitude;

    modport source (output valid, output cmd, output magnitude, input ready);
    modport sink (input valid, input cmd, input magnitude, output ready);
endinterface : mred_item_if
`default_nettype wire

>>> hw/rtl/mred_result_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mred_result_if
// result channel: edge byte and end-of-frame mark
// ----------------------------------------------------------------------------
interface mred_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] edge_byte;
    logic       last_of_frame;

    modport source (output valid, output edge_byte, output last_of_frame, input ready);
    modport sink (input valid, input edge_byte, input last_of_frame, output ready);
endinterface : mred_result_if
`default_nettype wire

>>> hw/rtl/mred_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mred_cfg_if
// configuration write channel: register index and data
// ----------------------------------------------------------------------------
interface mred_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface : mred_cfg_if
`default_nettype wire

>>> hw/rtl/mred_linebuf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mred_linebuf
// six line buffers in one memory word per column, read-modify-write with bypass
// ----------------------------------------------------------------------------
module mred_linebuf (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            en,
    input  wire [mred_pkg::COL_BITS-1:0]   rd_col,
    input  wire                            wr_valid,
    input  wire [mred_pkg::COL_BITS-1:0]   wr_col,
    input  wire [mred_pkg::PIXEL_BITS-1:0] wr_pix,
    output mred_pkg::line_entry_t          entry
);
    import mred_pkg::*;

    line_entry_t mem [MAX_WIDTH];
    line_entry_t rd_data_reg;
    line_entry_t fwd_data_reg;
    logic        fwd_reg;
    line_entry_t wr_data;

    // entry for the item now in the read stage, newest row pushed in at the bottom
    assign entry   = fwd_reg ? fwd_data_reg : rd_data_reg;
    assign wr_data = {entry[4:0], wr_pix};

    // memory port: write the shifted column, read the next one
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (wr_valid)
            begin
                mem[wr_col] <= wr_data;
            end
            rd_data_reg  <= mem[rd_col];
            fwd_data_reg <= wr_data;
        end
    end

    // bypass when the column read is the one being written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (en)
        begin
            fwd_reg <= wr_valid && (wr_col == rd_col);
        end
    end

endmodule : mred_linebuf
`default_nettype wire

>>> hw/rtl/mred_detect.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mred_detect
// three-scale ratio test: sums, min/max, products, compare and merge
// ----------------------------------------------------------------------------
module mred_detect (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   en,
    input  wire                   in_valid,
    input  mred_pkg::tag_t        in_tag,
    input  mred_pkg::win_t        window,
    input  mred_pkg::thr_set_t    thr,
    output logic                  out_valid,
    output logic [7:0]            out_edge_byte,
    output logic                  out_last
);
    import mred_pkg::*;

    typedef sum_t [2:0][3:0][2:0] pair_sums_t;
    typedef logic [PROD_BITS-1:0] prod_t;

    // line, block 1 and block 2 sums in four directions for half size h
    function automatic dir_sums_t scale_sums(input win_t win, input int h);
        dir_sums_t acc;
        int        off;
        int        dd [4];
        sum_t      v;
        acc = '0;
        off = 3 - h;
        for (int i = 0; i < 7; i++)
        begin
            for (int j = 0; j < 7; j++)
            begin
                if (i < 2 * h + 1 && j < 2 * h + 1)
                begin
                    v = sum_t'(win[off + i][off + j]);
                    dd[0] = j - h;
                    dd[1] = i - h;
                    dd[2] = i + j - 2 * h;
                    dd[3] = j - i;
                    for (int k = 0; k < 4; k++)
                    begin
                        if (dd[k] == 0)
                            acc[k][0] = acc[k][0] + v;
                        else if (dd[k] < 0)
                            acc[k][1] = acc[k][1] + v;
                        else
                            acc[k][2] = acc[k][2] + v;
                    end
                end
            end
        end
        return acc;
    endfunction

    dir_sums_t [2:0] sums_reg, sums_next;
    pair_sums_t      lo_reg, hi_reg, lo_next, hi_next;
    pair_sums_t      lo_e_reg;
    prod_t [2:0][3:0][2:0] prod_reg, prod_next;
    logic  c_valid_reg, d_valid_reg, e_valid_reg;
    tag_t  c_tag_reg, d_tag_reg, e_tag_reg;
    logic [2:0] scale_edge;

    // sums stage
    always_comb
    begin
        for (int s = 0; s < 3; s++)
        begin
            sums_next[s] = scale_sums(window, s + 1);
        end
    end

    // min/max stage, centre line scaled by h
    always_comb
    begin
        sum_t lm;
        sum_t a, b;
        lm = '0;
        a  = '0;
        b  = '0;
        for (int s = 0; s < 3; s++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                lm = sum_t'(sums_reg[s][k][0] * sum_t'(s + 1));
                for (int p = 0; p < 3; p++)
                begin
                    case (p)
                        0: begin a = lm; b = sums_reg[s][k][1]; end
                        1: begin a = lm; b = sums_reg[s][k][2]; end
                        default: begin a = sums_reg[s][k][1]; b = sums_reg[s][k][2]; end
                    endcase
                    lo_next[s][k][p] = (a < b) ? a : b;
                    hi_next[s][k][p] = (a < b) ? b : a;
                end
            end
        end
    end

    // product stage: threshold times larger mean
    always_comb
    begin
        for (int s = 0; s < 3; s++)
            for (int k = 0; k < 4; k++)
                for (int p = 0; p < 3; p++)
                    prod_next[s][k][p] = prod_t'(thr[s]) * prod_t'(hi_reg[s][k][p]);
    end

    // compare stage and merge of the three scales
    always_comb
    begin
        for (int s = 0; s < 3; s++)
        begin
            scale_edge[s] = 1'b0;
            for (int k = 0; k < 4; k++)
                for (int p = 0; p < 3; p++)
                    if ((prod_t'(lo_e_reg[s][k][p]) << THR_BITS) < prod_reg[s][k][p])
                        scale_edge[s] = 1'b1;
            scale_edge[s] = scale_edge[s] && e_tag_reg.fits[s];
        end
    end

    assign out_valid     = e_valid_reg && e_tag_reg.emit;
    assign out_last      = e_tag_reg.last;
    assign out_edge_byte = (scale_edge[0] && (scale_edge[1] || scale_edge[2]))
                           ? EDGE_YES : EDGE_NO;

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sums_reg <= sums_next;
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            lo_e_reg <= lo_reg;
            prod_reg <= prod_next;
            c_tag_reg <= in_tag;
            d_tag_reg <= c_tag_reg;
            e_tag_reg <= d_tag_reg;
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c_valid_reg <= in_valid;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

endmodule : mred_detect
`default_nettype wire

>>> hw/rtl/multiscale_ratio_edge_detector_top.sv
// Pipeline: the transaction that completes a result's 7x7 neighbourhood (3*width+3
//   pixels after its own pixel) passes the read, window, sums, min/max, product and output registers.
// Throughput: one transaction per cycle; the pipeline freezes only while the
//   output register holds a result that is not taken.
// Reset: counters, valid bits and configuration registers return to their defaults at once;
//   line buffer and window contents are undefined until written.
`default_nettype none
// ----------------------------------------------------------------------------
// multiscale_ratio_edge_detector_top
// raster pixel stream in, edge byte per pixel out, three-scale ratio test
// ----------------------------------------------------------------------------
module multiscale_ratio_edge_detector_top (
    input  wire              clk,
    input  wire              rst_n,
    mred_item_if.sink        pixels,
    mred_result_if.source    results,
    mred_cfg_if.sink         cfg
);
    import mred_pkg::*;

    localparam int LAG_BITS = COL_BITS + 4;

    // configuration registers
    thr_set_t    thr_reg;
    logic [11:0] width_reg;
    logic [15:0] height_reg;

    // frame position
    logic [COL_BITS-1:0] in_col_reg, in_col_next;
    logic [16:0]         in_row_reg, in_row_next;
    logic [COL_BITS-1:0] out_col_reg, out_col_next;
    logic [15:0]         out_row_reg, out_row_next;
    logic [LAG_BITS-1:0] lead_reg, lead_next;

    logic [11:0]         w_eff;
    logic [15:0]         ht_eff;
    logic [LAG_BITS-1:0] lag;
    logic                en, accept, row_live, eff, emit, last, cfg_restart;
    logic [COL_BITS-1:0] col;
    pixel_t              pix;
    tag_t                tag;

    // read stage
    logic                a_valid_reg;
    logic [COL_BITS-1:0] a_col_reg;
    pixel_t              a_pix_reg;
    tag_t                a_tag_reg;
    line_entry_t         entry;

    // window stage
    logic b_valid_reg;
    tag_t b_tag_reg;
    win_t window_reg;

    // output register
    logic       det_valid, det_last;
    logic [7:0] det_byte;
    logic       res_valid_reg, res_last_reg;
    logic [7:0] res_byte_reg;

    assign en           = !res_valid_reg || results.ready;
    assign pixels.ready = en;
    assign cfg.ready    = 1'b1;
    assign accept       = pixels.valid && pixels.ready;
    assign cfg_restart  = cfg.valid && ((cfg.index == CFG_WIDTH) || (cfg.index == CFG_HEIGHT));

    // effective frame size and output lag
    always_comb
    begin
        if (width_reg == 12'd0)
            w_eff = 12'd1;
        else if (width_reg > 12'(MAX_WIDTH))
            w_eff = 12'(MAX_WIDTH);
        else
            w_eff = width_reg;
        ht_eff = (height_reg == 16'd0) ? 16'd1 : height_reg;
        lag    = LAG_BITS'({w_eff, 1'b0}) + LAG_BITS'(w_eff) + LAG_BITS'(3);
    end

    // position tracking and per-transaction control
    always_comb
    begin
        row_live = in_row_reg < {1'b0, ht_eff};
        eff      = accept && (row_live ? !pixels.cmd : 1'b1);
        col      = ({1'b0, in_col_reg} >= w_eff) ? '0 : in_col_reg;
        pix      = row_live ? pixels.magnitude[PIXEL_BITS-1:0] : '0;
        emit     = lead_reg == lag;
        last     = emit && ((17'(out_row_reg) + 17'd1) >= {1'b0, ht_eff})
                        && ((12'(out_col_reg) + 12'd1) >= w_eff);
        for (int s = 0; s < 3; s++)
        begin
            tag.fits[s] = (12'(out_col_reg) >= 12'(s + 1))
                       && ((12'(out_col_reg) + 12'(s + 1)) < w_eff)
                       && (17'(out_row_reg) >= 17'(s + 1))
                       && ((17'(out_row_reg) + 17'(s + 1)) < {1'b0, ht_eff});
        end
        tag.emit = emit;
        tag.last = last;

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        lead_next    = lead_reg;
        if (eff)
        begin
            if ((12'(col) + 12'd1) >= w_eff)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + 17'd1;
            end
            else
            begin
                in_col_next = col + COL_BITS'(1);
            end
            if (!emit)
            begin
                lead_next = lead_reg + LAG_BITS'(1);
            end
            else if ((12'(out_col_reg) + 12'd1) >= w_eff)
            begin
                out_col_next = '0;
                out_row_next = out_row_reg + 16'd1;
            end
            else
            begin
                out_col_next = out_col_reg + COL_BITS'(1);
            end
            if (last)
            begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
                lead_next    = '0;
            end
        end
        if (cfg_restart)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            lead_next    = '0;
        end
    end

    // configuration and position registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg[0]  <= 16'd42598;
            thr_reg[1]  <= 16'd32768;
            thr_reg[2]  <= 16'd26214;
            width_reg   <= 12'd1024;
            height_reg  <= 16'd1024;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            lead_reg    <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_THR_SMALL:  thr_reg[0] <= cfg.data;
                    CFG_THR_MEDIUM: thr_reg[1] <= cfg.data;
                    CFG_THR_LARGE:  thr_reg[2] <= cfg.data;
                    CFG_WIDTH:      width_reg  <= cfg.data[11:0];
                    CFG_HEIGHT:     height_reg <= cfg.data;
                    default: ;
                endcase
            end
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            lead_reg    <= lead_next;
        end
    end

    // line buffers
    mred_linebuf u_linebuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .rd_col   (col),
        .wr_valid (a_valid_reg),
        .wr_col   (a_col_reg),
        .wr_pix   (a_pix_reg),
        .entry    (entry)
    );

    // read stage and window stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_col_reg <= col;
            a_pix_reg <= pix;
            a_tag_reg <= tag;
            b_tag_reg <= a_tag_reg;
            if (a_valid_reg)
            begin
                for (int r = 0; r < 7; r++)
                    for (int k = 0; k < 6; k++)
                        window_reg[r][k] <= window_reg[r][k + 1];
                for (int k = 0; k < 6; k++)
                    window_reg[k][6] <= entry[5 - k];
                window_reg[6][6] <= a_pix_reg;
            end
        end
    end

    // read and window stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= eff;
            b_valid_reg <= a_valid_reg;
        end
    end

    // ratio tests
    mred_detect u_detect (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (b_valid_reg),
        .in_tag        (b_tag_reg),
        .window        (window_reg),
        .thr           (thr_reg),
        .out_valid     (det_valid),
        .out_edge_byte (det_byte),
        .out_last      (det_last)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            res_valid_reg <= det_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_byte_reg <= det_byte;
            res_last_reg <= det_last;
        end
    end

    assign results.valid         = res_valid_reg;
    assign results.edge_byte     = res_byte_reg;
    assign results.last_of_frame = res_last_reg;

`ifndef SYNTHESIS
    // a result byte is only ever edge or no edge
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_byte_reg == EDGE_YES || res_byte_reg == EDGE_NO))
        else $error("result byte neither edge nor no-edge");

    // output column stays inside the effective row
    assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, out_col_reg} < w_eff)
        else $error("output column beyond row width");

    // lead counter saturates at the output lag
    assert property (@(posedge clk) disable iff (!rst_n)
        !cfg.valid |=> lead_reg <= lag)
        else $error("lead counter past output lag");
`endif

endmodule : multiscale_ratio_edge_detector_top
`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multiscale ratio edge detector. It streams raster
// frames of several sizes and threshold settings, with flush ticks and mixed
// source and sink idling. A local model predicts each edge byte and end-of-frame
// mark, and every result transaction is checked against it in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mred_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 12;

    // edge predictor and store of expected results
    class edge_scoreboard;
        bit [15:0] rows[6][MAX_WIDTH];
        bit [15:0] win[7][7];
        int unsigned in_c, in_r, out_c, out_r;
        bit [15:0] thr[3];
        bit [11:0] width;
        bit [15:0] height;
        bit [8:0]  expected[$];   // {last_of_frame, edge_byte}
        int        errors;

        function new();
            foreach (rows[k, c]) rows[k][c] = '0;
            foreach (win[r, c]) win[r][c] = '0;
            restart();
            thr[0] = 16'd42598;
            thr[1] = 16'd32768;
            thr[2] = 16'd26214;
            width  = 12'd1024;
            height = 16'd1024;
            errors = 0;
        endfunction

        function void restart();
            in_c = 0; in_r = 0; out_c = 0; out_r = 0;
        endfunction

        function int unsigned cols();
            if (width == 0) return 1;
            if (width > MAX_WIDTH) return MAX_WIDTH;
            return width;
        endfunction

        function int unsigned lines();
            return (height == 0) ? 1 : height;
        endfunction

        function void configure(logic [2:0] idx, logic [15:0] data);
            case (idx)
                CFG_THR_SMALL:  thr[0] = data;
                CFG_THR_MEDIUM: thr[1] = data;
                CFG_THR_LARGE:  thr[2] = data;
                CFG_WIDTH:      begin width = data[11:0]; restart(); end
                CFG_HEIGHT:     begin height = data; restart(); end
                default: ;
            endcase
        endfunction

        function bit ratio_low(longint unsigned a, longint unsigned b, bit [15:0] t);
            longint unsigned lo, hi;
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            return (lo * 65536) < (longint'(t) * hi);
        endfunction

        // one scale: centre line mean against each side-block mean, and the two side blocks against each other
        function bit scale_has_edge(int h, bit [15:0] t);
            longint unsigned ln[4], s1[4], s2[4];
            int d[4];
            int off;
            off = 3 - h;
            for (int k = 0; k < 4; k++) begin ln[k] = 0; s1[k] = 0; s2[k] = 0; end
            for (int i = 0; i < 2*h+1; i++)
                for (int j = 0; j < 2*h+1; j++) begin
                    d[0] = j - h; d[1] = i - h; d[2] = i + j - 2*h; d[3] = j - i;
                    for (int k = 0; k < 4; k++)
                        if (d[k] == 0) ln[k] += win[off+i][off+j];
                        else if (d[k] < 0) s1[k] += win[off+i][off+j];
                        else s2[k] += win[off+i][off+j];
                end
            for (int k = 0; k < 4; k++)
                if (ratio_low(ln[k]*h, s1[k], t) || ratio_low(ln[k]*h, s2[k], t) ||
                    ratio_low(s1[k], s2[k], t))
                    return 1'b1;
            return 1'b0;
        endfunction

        function bit inside_frame(int unsigned h, int unsigned w, int unsigned ht);
            return out_c >= h && out_c + h < w && out_r >= h && out_r + h < ht;
        endfunction

        // accepted input transaction: advance the model, queue any result
        function void note_item(bit cmd, bit [15:0] mag);
            int unsigned w, ht, c;
            bit [15:0] v;
            longint unsigned pos;
            bit edge_small, edge_conf, fin;
            w = cols(); ht = lines();
            if (!cmd && in_r < ht) v = mag;
            else if (in_r >= ht) v = '0;
            else return;
            if (in_c >= w) in_c = 0;
            c = in_c;
            pos = longint'(in_r) * w + c;
            for (int r = 0; r < 7; r++)
                for (int k = 0; k < 6; k++) win[r][k] = win[r][k+1];
            for (int k = 0; k < 6; k++) win[k][6] = rows[5-k][c];
            win[6][6] = v;
            for (int k = 5; k > 0; k--) rows[k][c] = rows[k-1][c];
            rows[0][c] = v;
            in_c++;
            if (in_c >= w) begin in_c = 0; in_r++; end
            if (pos < 3*longint'(w) + 3) return;
            edge_small = inside_frame(1, w, ht) && scale_has_edge(1, thr[0]);
            edge_conf  = (inside_frame(2, w, ht) && scale_has_edge(2, thr[1])) ||
                         (inside_frame(3, w, ht) && scale_has_edge(3, thr[2]));
            fin = (out_r + 1 >= ht) && (out_c + 1 >= w);
            expected.push_back({fin, (edge_small && edge_conf) ? EDGE_YES : EDGE_NO});
            if (fin) restart();
            else begin
                out_c++;
                if (out_c >= w) begin out_c = 0; out_r++; end
            end
        endfunction

        function void check_result(logic [7:0] eb, logic lf);
            bit [8:0] exp_res;
            if (expected.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result: edge_byte %0d last %0b", eb, lf);
                return;
            end
            exp_res = expected.pop_front();
            if ({lf, eb} !== exp_res) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: edge_byte exp %0d got %0d, last exp %0b got %0b",
                             exp_res[7:0], eb, exp_res[8], lf);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    mred_item_if   pix();
    mred_result_if res();
    mred_cfg_if    cfg();

    edge_scoreboard sb;
    int src_idle_pct;
    int sink_stall_pct;
    int holdoff;
    int cycles;

    multiscale_ratio_edge_detector_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pix.sink),
        .results (res.source),
        .cfg     (cfg.sink)
    );

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // sink side: random stalls and long hold-offs
    always @(posedge clk)
    begin
        if (holdoff > 0)
        begin
            holdoff--;
            res.ready <= 1'b0;
        end
        else
            res.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // transaction monitors
    always @(posedge clk)
    begin
        if (rst_n && pix.valid && pix.ready) sb.note_item(pix.cmd, pix.magnitude);
        if (rst_n && res.valid && res.ready) sb.check_result(res.edge_byte, res.last_of_frame);
        if (rst_n && cfg.valid && cfg.ready) sb.configure(cfg.index, cfg.data);
    end

    task automatic send_item(input bit cmd, input bit [15:0] mag);
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct)
        begin
            pix.valid <= 1'b0;
            @(posedge clk);
        end
        pix.valid     <= 1'b1;
        pix.cmd       <= cmd;
        pix.magnitude <= mag;
        do @(posedge clk); while (!pix.ready);
    endtask

    task automatic pause_until_drained();
        pix.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic bit [15:0] pixel_value(int style, bit [15:0] base);
        int unsigned v;
        case (style)
            0: return 16'($urandom());
            1: begin
                v = base + $urandom_range(0, base >> 2);
                return (v > 65535) ? 16'hFFFF : v[15:0];
            end
            default: return ($urandom_range(0, 1) != 0) ? 16'hFFFF
                                                        : 16'($urandom_range(0, 15));
        endcase
    endfunction

    // one frame of pixels with stray flushes, then the drain ticks
    task automatic stream_frame(input int unsigned w, input int unsigned npix);
        int style;
        bit [15:0] base;
        style = $urandom_range(0, 2);
        base  = 16'($urandom());
        for (int i = 0; i < npix; i++)
        begin
            if ($urandom_range(99) < 5) send_item(1'b1, 16'($urandom()));
            send_item(1'b0, pixel_value(style, base));
        end
        for (int i = 0; i < 3*w + 3; i++)
            send_item(1'($urandom_range(0, 1)), 16'($urandom()));
        // flush after the frame has closed is ignored
        send_item(1'b1, 16'($urandom()));
    endtask

    task automatic set_thresholds(input int p);
        if (p == 0)
        begin
            write_reg(CFG_THR_SMALL, 16'h0000);
            write_reg(CFG_THR_MEDIUM, 16'h0000);
            write_reg(CFG_THR_LARGE, 16'h0000);
        end
        else if (p == 1)
        begin
            write_reg(CFG_THR_SMALL, 16'hFFFF);
            write_reg(CFG_THR_MEDIUM, 16'hFFFF);
            write_reg(CFG_THR_LARGE, 16'hFFFF);
        end
        else
        begin
            write_reg(CFG_THR_SMALL, 16'($urandom_range(30000, 65535)));
            write_reg(CFG_THR_MEDIUM, 16'($urandom_range(15000, 60000)));
            write_reg(CFG_THR_LARGE, 16'($urandom_range(10000, 55000)));
        end
    endtask

    initial
    begin
        int unsigned w, h;
        sb = new();
        cycles = 0;
        holdoff = 0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        rst_n = 1'b0;
        clk = 1'b0;
        pix.valid = 1'b0;
        pix.cmd = 1'b0;
        pix.magnitude = '0;
        res.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = CFG_THR_SMALL;
        cfg.data = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: 3x3 frame, only the small window fits (at the centre), extremes and flush corners
        write_reg(CFG_WIDTH, 16'd3);
        write_reg(CFG_HEIGHT, 16'd3);
        send_item(1'b1, 16'hFFFF);
        for (int i = 0; i < 9; i++)
        begin
            send_item(1'b0, (i % 2) ? 16'hFFFF : 16'h0000);
            if (i == 4) send_item(1'b1, 16'h1234);
        end
        send_item(1'b0, 16'hFFFF);
        for (int i = 0; i < 11; i++) send_item(1'b1, 16'h0000);
        send_item(1'b1, 16'h0000);
        pause_until_drained();

        // random frames across idle patterns and settings
        for (int p = 0; p < 8; p++)
        begin
            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 77; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 77; end
                default: begin src_idle_pct = 38; sink_stall_pct = 38; end
            endcase
            set_thresholds(p);
            if (p == 2)
            begin
                write_reg(CFG_WIDTH, 16'd0);
                write_reg(CFG_HEIGHT, 16'd6);
                w = 1; h = 6;
            end
            else if (p == 3)
            begin
                write_reg(CFG_WIDTH, 16'd9);
                write_reg(CFG_HEIGHT, 16'd0);
                w = 9; h = 1;
            end
            else
            begin
                w = $urandom_range(5, 10);
                h = $urandom_range(5, 8);
                write_reg(CFG_WIDTH, 16'(w));
                write_reg(CFG_HEIGHT, 16'(h));
            end
            if (p == 4) holdoff = 300;
            stream_frame(w, w*h);
            pause_until_drained();
        end

        // wide row, width register beyond the maximum, frame cut short
        src_idle_pct = 0;
        sink_stall_pct = 0;
        set_thresholds(5);
        write_reg(CFG_WIDTH, 16'd4095);
        write_reg(CFG_HEIGHT, 16'd3);
        for (int i = 0; i < 32; i++) send_item(1'b0, 16'($urandom()));
        pause_until_drained();

        // tallest height, frame cut short by a height write
        src_idle_pct = 38;
        sink_stall_pct = 38;
        write_reg(CFG_WIDTH, 16'd8);
        write_reg(CFG_HEIGHT, 16'd65535);
        for (int i = 0; i < 40; i++) send_item(1'b0, 16'($urandom()));
        pause_until_drained();
        write_reg(CFG_HEIGHT, 16'd7);
        stream_frame(8, 56);
        pause_until_drained();

        if (sb.errors == 0 && sb.expected.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule : tb
`default_nettype wire
